// ----- design/stli_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants for the sorted table interpolator
// Request/response payloads, table entry layout, command and status codes,
// and the sequencer state encoding.
// ----------------------------------------------------------------------------
package stli_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Divider: one quotient bit per step over a 32-bit dividend magnitude
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [15:0]  key;
        logic signed [15:0]  value_in;
    } stli_req_t;

    typedef struct packed {
        logic signed [15:0]  result_value;
        logic [1:0]          status;
    } stli_rsp_t;

    typedef struct packed {
        logic signed [15:0]  key;
        logic signed [15:0]  value;
    } stli_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_WR,
        S_Q_LAST,
        S_Q_CHK,
        S_MUL,
        S_ABS,
        S_DIV,
        S_FIN,
        S_EMIT
    } stli_state_t;

endpackage
`default_nettype wire

// ----- design/stli_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stli_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- design/sorted_table_linear_interpolator_unit.sv -----
`default_nettype none
// Sequence, accept to response: clear, unused code, full insert and empty-table
// query go straight to the response; insert moves each entry with a larger key
// up one slot; query checks the last key first, then scans neighbor pairs for a
// match, a miss or an interpolation between entries j-1 and j (32 div steps).
// One request in flight; the next can be taken in the cycle after the response is loaded.
// Reset clears the entry count and the sequencer; table contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_unit: sorted breakpoint table with
// piecewise linear interpolation
// Keeps (key, value) pairs in ascending key order in one RAM, inserts in
// sorted position, and answers exact-match or interpolated queries.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire stli_pkg::stli_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output stli_pkg::stli_rsp_t      rsp
);
    import stli_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    stli_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;

    stli_rsp_t           rsp_reg, rsp_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;      // insert slot being filled
    logic [ADDR_W-1:0]   idx_reg, idx_next;      // index of entry on read data
    logic signed [15:0]  t_reg, t_next;          // key / query target
    logic signed [15:0]  v_reg, v_next;          // value to insert
    stli_entry_t         prev_reg, prev_next;    // lower neighbor in scan
    logic signed [15:0]  y0_reg, y0_next;
    logic signed [16:0]  dy_reg, dy_next;
    logic signed [16:0]  dt_reg, dt_next;
    logic [16:0]         dx_reg, dx_next;
    logic signed [33:0]  prod_reg, prod_next;
    logic [31:0]         quo_reg, quo_next;      // dividend in, quotient out
    logic [16:0]         rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic signed [15:0]  res_value_reg, res_value_next;
    logic [1:0]          res_status_reg, res_status_next;

    // ------------------------------------------------------------------
    // Table RAM: {key, value} per entry
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_wa;
    stli_entry_t         ram_wd;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_ra;
    logic [$bits(stli_entry_t)-1:0] ram_rd_data;
    stli_entry_t         rd;

    stli_ram #(
        .WIDTH ($bits(stli_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd_data)
    );

    assign rd = stli_entry_t'(ram_rd_data);

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    logic               accept;
    logic               emit_ok;
    logic               full;
    logic               empty;
    logic               single;
    logic               ins_shift;
    logic               pos_last;
    logic               last_hit;
    logic               first;
    logic               eq_prev;
    logic               bracket;
    logic               more;
    logic               div_last;
    logic [17:0]        rem_sh;
    logic               div_ge;
    logic signed [33:0] prod_abs;
    logic signed [17:0] q_signed;
    logic signed [17:0] interp_sum;
    stli_entry_t        new_entry;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign emit_ok   = !rsp_valid_reg || rsp_ready;

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign empty     = (count_reg == '0);
    assign single    = (count_reg == CNT_W'(1));

    // Insert: entries with a larger key move up; equal keys stay below
    assign ins_shift = (rd.key > t_reg);
    assign pos_last  = (pos_reg == ADDR_W'(1));
    assign new_entry = '{key: t_reg, value: v_reg};

    // Query: last entry checked first, then neighbor pairs in order
    assign last_hit  = (rd.key == t_reg);
    assign first     = (idx_reg == '0);
    assign eq_prev   = (prev_reg.key == t_reg);
    assign bracket   = (t_reg > prev_reg.key) && (t_reg < rd.key);
    assign more      = ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg);

    // Restoring divider step on magnitudes
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign rem_sh    = {rem_reg, quo_reg[31]};
    assign div_ge    = (rem_sh >= {1'b0, dx_reg});
    assign prod_abs  = prod_reg[33] ? -prod_reg : prod_reg;

    // Quotient magnitude is below |dy|, so 17 bits carry it
    assign q_signed   = neg_reg ? -$signed({1'b0, quo_reg[16:0]})
                                :  $signed({1'b0, quo_reg[16:0]});
    assign interp_sum = 18'(y0_reg) + q_signed;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.command)
                        CMD_INSERT:
                        begin
                            if (full)
                                state_next = S_EMIT;
                            else if (empty)
                                state_next = S_INS_WR;
                            else
                                state_next = S_INS_CMP;
                        end
                        CMD_QUERY:
                        begin
                            state_next = empty ? S_EMIT : S_Q_LAST;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_INS_CMP:
            begin
                if (ins_shift)
                    state_next = pos_last ? S_INS_WR : S_INS_CMP;
                else
                    state_next = S_EMIT;
            end
            S_INS_WR:
            begin
                state_next = S_EMIT;
            end
            S_Q_LAST:
            begin
                state_next = (last_hit || single) ? S_EMIT : S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (first)
                    state_next = S_Q_CHK;
                else if (eq_prev)
                    state_next = S_EMIT;
                else if (bracket)
                    state_next = S_MUL;
                else if (more)
                    state_next = S_Q_CHK;
                else
                    state_next = S_EMIT;
            end
            S_MUL:
            begin
                state_next = S_ABS;
            end
            S_ABS:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = div_last ? S_FIN : S_DIV;
            end
            S_FIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = emit_ok ? S_IDLE : S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM control
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        t_next          = t_reg;
        v_next          = v_reg;
        prev_next       = prev_reg;
        y0_next         = y0_reg;
        dy_next         = dy_reg;
        dt_next         = dt_reg;
        dx_next         = dx_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        div_cnt_next    = div_cnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        ram_we = 1'b0;
        ram_wa = pos_reg;
        ram_wd = new_entry;
        ram_re = 1'b0;
        ram_ra = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    t_next          = req.key;
                    v_next          = req.value_in;
                    res_value_next  = '0;
                    res_status_next = STAT_DONE;
                    case (req.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                pos_next = count_reg[ADDR_W-1:0];
                                if (!empty)
                                begin
                                    ram_re = 1'b1;
                                    ram_ra = ADDR_W'(count_reg - CNT_W'(1));
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (empty)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                                ram_ra = ADDR_W'(count_reg - CNT_W'(1));
                            end
                        end
                        default:
                        begin
                            // unused code: no table change
                        end
                    endcase
                end
            end
            S_INS_CMP:
            begin
                // rd holds entry pos-1; write slot pos, read pos-2 ahead
                ram_we = 1'b1;
                if (ins_shift)
                begin
                    ram_wd   = rd;
                    pos_next = pos_reg - ADDR_W'(1);
                    if (!pos_last)
                    begin
                        ram_re = 1'b1;
                        ram_ra = pos_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            S_Q_LAST:
            begin
                if (last_hit)
                begin
                    res_value_next = rd.value;
                end
                else if (single)
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
                else
                begin
                    ram_re   = 1'b1;
                    ram_ra   = '0;
                    idx_next = '0;
                end
            end
            S_Q_CHK:
            begin
                if (first || (!eq_prev && !bracket && more))
                begin
                    prev_next = rd;
                    ram_re    = 1'b1;
                    ram_ra    = idx_reg + ADDR_W'(1);
                    idx_next  = idx_reg + ADDR_W'(1);
                end
                else if (eq_prev)
                begin
                    res_value_next = prev_reg.value;
                end
                else if (bracket)
                begin
                    y0_next = prev_reg.value;
                    dy_next = 17'(rd.value) - 17'(prev_reg.value);
                    dt_next = 17'(t_reg) - 17'(prev_reg.key);
                    dx_next = 17'(17'(rd.key) - 17'(prev_reg.key));
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                end
            end
            S_MUL:
            begin
                prod_next = 34'(dt_reg) * 34'(dy_reg);
            end
            S_ABS:
            begin
                quo_next     = prod_abs[31:0];
                neg_next     = prod_reg[33];
                rem_next     = '0;
                div_cnt_next = '0;
            end
            S_DIV:
            begin
                rem_next     = div_ge ? 17'(rem_sh - {1'b0, dx_reg}) : rem_sh[16:0];
                quo_next     = {quo_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            S_FIN:
            begin
                res_value_next = interp_sum[15:0];
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    rsp_next.result_value = res_value_reg;
                    rsp_next.status       = res_status_reg;
                    rsp_valid_next        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        t_reg          <= t_next;
        v_reg          <= v_next;
        prev_reg       <= prev_next;
        y0_reg         <= y0_next;
        dy_reg         <= dy_next;
        dt_reg         <= dt_next;
        dx_reg         <= dx_next;
        prod_reg       <= prod_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        neg_reg        <= neg_next;
        div_cnt_reg    <= div_cnt_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // entry count never passes the table depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // shift read runs ahead of the write; never the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_wa != ram_ra))
        else $error("RAM read and write hit the same entry");

    // inserts only write while there is room
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("table write with table full");

    // clear empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.command == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    // interpolation quotient fits in 17 bits
    a_quo_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (quo_reg[31:17] == '0))
        else $error("interpolation quotient overflow");

endmodule
`default_nettype wire
